/* hw/rtl/gwme_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwme_pkg
// Shared widths, limits and reset values for the greedy makespan estimator.
// ----------------------------------------------------------------------------
package gwme_pkg;

  localparam int MAX_WORKERS_DEF = 16;
  localparam int TIME_W          = 32;
  localparam int SUM_W           = 48;
  localparam int NW_W            = 5;
  localparam int WID_W           = 4;

  localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};
  localparam logic [NW_W-1:0]  NW_RST      = 5'd16;

endpackage

/* hw/rtl/gwme_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwme_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gwme_ram #(
  parameter  int WIDTH  = 32,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  logic [WIDTH-1:0]    wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output logic [WIDTH-1:0]    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/greedy_worker_makespan_estimator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_worker_makespan_estimator_core
// Greedy list scheduling of task durations onto a set of workers.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_data set the worker count (0 counts as 1, values above
//   MAX_WORKERS count as MAX_WORKERS); write it only while the block is idle.
//   s_axis carries one task duration per transaction, tlast marks the end
//   of a run. m_axis returns one result per task: assigned worker, makespan
//   and total work; tlast flags the result that closes the run.
//   Each task takes two passes: one scan over the remaining-time RAM to
//   find an idle worker or the minimum, then one read-modify-write pass
//   over both worker RAMs that ages the workers, books the task and finds
//   the largest busy time. Each pass waits on the registered read, and
//   the single read port of each RAM serves one worker at a time.
//   s_axis_tready is low while a task is in work, so a new task is taken
//   only once the previous one has left the update pass.
//   The result sits in an output register; the next task is taken while it
//   waits, and a finished result stalls only until that register frees.
//   Reset clears all worker state through per-entry valid bits at once, so
//   no clearing pass is needed; the end of a run clears them the same way.
// ----------------------------------------------------------------------------
module greedy_worker_makespan_estimator_core
  import gwme_pkg::*;
#(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [NW_W-1:0]  cfg_data,       // num_workers
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,   // task_time[31:0]
  input  logic             s_axis_tlast,   // last_task
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [103:0]     m_axis_tdata,   // assigned_worker[3:0], makespan[51:4],
                                           // total_work[99:52], zero fill
  output logic             m_axis_tlast    // run_done
);

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W = $clog2(MAX_WORKERS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;

  logic [NW_W-1:0]        num_workers;
  logic [SUM_W-1:0]       work_sum;
  logic [MAX_WORKERS-1:0] valid;

  logic [TIME_W-1:0]      t_q;
  logic                   last_q;
  logic [CNT_W-1:0]       n_q;
  logic [CNT_W-1:0]       cnt;
  logic                   rd_vld;
  logic [IDX_W-1:0]       rd_idx;
  logic                   vrd;
  logic                   found;
  logic [IDX_W-1:0]       sel;
  logic [TIME_W-1:0]      least;
  logic [SUM_W-1:0]       span;

  logic [WID_W-1:0]       out_worker;
  logic [SUM_W-1:0]       out_span;
  logic [SUM_W-1:0]       out_total;
  logic                   out_last;
  logic                   out_valid;

  logic [CNT_W-1:0]       n_act;
  logic [31:0]            nw_ext;
  logic                   in_acc;
  logic                   issue;
  logic                   load;
  logic [SUM_W:0]         wsum;
  logic [TIME_W-1:0]      rem_dout;
  logic [SUM_W-1:0]       busy_dout;
  logic [TIME_W-1:0]      rem_v;
  logic [SUM_W-1:0]       busy_v;
  logic [SUM_W:0]         bsum;
  logic [SUM_W-1:0]       busy_new;
  logic [TIME_W-1:0]      rem_new;
  logic                   wr_en;
  logic [IDX_W+WID_W-1:0] sel_ext;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign issue         = (state inside {ST_SCAN, ST_UPDATE}) && (cnt < n_q);
  assign load          = (state == ST_FINISH) && (!out_valid || m_axis_tready);
  assign wr_en         = (state == ST_UPDATE) && rd_vld;

  always_comb begin
    nw_ext = {27'd0, num_workers};
    if (nw_ext == 32'd0) begin
      n_act = CNT_W'(1);
    end else if (nw_ext > 32'(MAX_WORKERS)) begin
      n_act = CNT_W'(MAX_WORKERS);
    end else begin
      n_act = CNT_W'(nw_ext);
    end
  end

  assign wsum   = {1'b0, work_sum} + {17'd0, s_axis_tdata};
  assign rem_v  = vrd ? rem_dout : '0;
  assign busy_v = vrd ? busy_dout : '0;
  assign bsum   = {1'b0, busy_v} + {17'd0, t_q};

  always_comb begin
    if (rd_idx == sel) begin
      rem_new  = t_q;
      busy_new = bsum[SUM_W] ? SUM_MAX : bsum[SUM_W-1:0];
    end else begin
      rem_new  = found ? rem_v : rem_v - least;
      busy_new = busy_v;
    end
  end

  assign sel_ext = {{WID_W{1'b0}}, sel};

  gwme_ram #(.WIDTH(TIME_W), .DEPTH(MAX_WORKERS)) u_rem_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (rd_idx),
    .wdata (rem_new),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (rem_dout)
  );

  gwme_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WORKERS)) u_busy_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (rd_idx),
    .wdata (busy_new),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (busy_dout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      num_workers <= NW_RST;
      work_sum    <= '0;
      valid       <= '0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        num_workers <= cfg_data;
      end

      rd_vld <= issue;
      if (issue) begin
        rd_idx <= cnt[IDX_W-1:0];
        vrd    <= valid[cnt[IDX_W-1:0]];
        cnt    <= cnt + CNT_W'(1);
      end

      if (wr_en) begin
        valid[rd_idx] <= 1'b1;
      end

      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            t_q      <= s_axis_tdata;
            last_q   <= s_axis_tlast;
            n_q      <= n_act;
            cnt      <= '0;
            found    <= 1'b0;
            work_sum <= wsum[SUM_W] ? SUM_MAX : wsum[SUM_W-1:0];
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_vld && !found) begin
            if (rem_v == '0) begin
              found <= 1'b1;
              sel   <= rd_idx;
            end else if (rd_idx == '0 || rem_v < least) begin
              least <= rem_v;
              sel   <= rd_idx;
            end
          end
          if (cnt == n_q && !rd_vld) begin
            cnt   <= '0;
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (rd_vld) begin
            if (rd_idx == '0 || busy_new > span) begin
              span <= busy_new;
            end
          end
          if (cnt == n_q && !rd_vld) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (load) begin
            out_worker <= sel_ext[WID_W-1:0];
            out_span   <= span;
            out_total  <= work_sum;
            out_last   <= last_q;
            if (last_q) begin
              valid    <= '0;
              work_sum <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_total, out_span, out_worker};
  assign m_axis_tlast  = out_last;

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (load && last_q) |=> (valid == '0 && work_sum == '0))
    else $error("worker state not cleared at end of run");

  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_SCAN && cnt == '0 && !found))
    else $error("scan did not start after task accept");

  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> ({{CNT_W{1'b0}}, sel} < {{IDX_W{1'b0}}, n_q}))
    else $error("selected worker outside active count");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_UPDATE) |-> (cnt <= n_q))
    else $error("pass counter overran active count");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !wr_en)
    else $error("RAM write during scan pass");

endmodule
